// ===== rtl/rpb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpb_pkg
// Shared types, codes and helpers for the RGBA4444 pixel blend pipeline.
// ----------------------------------------------------------------------------
package rpb_pkg;

    typedef enum logic [3:0] {
        KIND_ALPHA    = 4'd0,
        KIND_COPY     = 4'd1,
        KIND_MASK     = 4'd2,
        KIND_PEN      = 4'd3,
        KIND_DARKEN   = 4'd4,
        KIND_LIGHTEN  = 4'd5,
        KIND_ADD      = 4'd6,
        KIND_SUBTRACT = 4'd7,
        KIND_MULTIPLY = 4'd8,
        KIND_DISSOLVE = 4'd9
    } t_kind;

    typedef enum logic [1:0] {
        OP_KEEP     = 2'd0,
        OP_SRC      = 2'd1,
        OP_BLEND    = 2'd2,
        OP_DISSOLVE = 2'd3
    } t_op;

    typedef enum logic {
        CFG_GLOBAL_ALPHA = 1'b0,
        CFG_PEN_COLOR    = 1'b1
    } t_cfg_index;

    localparam int PIX_W      = 16;
    localparam int HASH_W     = 20;
    localparam int ALPHA_W    = 5;
    localparam logic [3:0]  GLOBAL_ALPHA_RST = 4'hf;
    localparam logic [15:0] PEN_COLOR_RST    = 16'h0000;
    localparam logic [31:0] HASH_MULT        = 32'h0000_00d2;

    typedef struct packed {
        t_op               op;
        logic [PIX_W-1:0]  pix;
        logic [PIX_W-1:0]  dst;
        logic [HASH_W-1:0] hash;
        logic              last;
    } t_s1;

    typedef struct packed {
        t_op                op;
        logic [ALPHA_W-1:0] alpha;
        logic [PIX_W-1:0]   pix;
        logic [PIX_W-1:0]   dst;
        logic               last;
    } t_s2;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             we;
        logic             last;
    } t_s3;

    function automatic logic [31:0] hash_round(input logic [31:0] v, input logic [2:0] n);
        return (((v >> 8) ^ v) * HASH_MULT) + 32'(n);
    endfunction

endpackage

// ===== rtl/rgba4444_pixel_blend_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba4444_pixel_blend_unit
// Blends an RGBA4444 source pixel into a destination pixel under one of ten
// modes and returns the new destination pixel with a write enable.
//
// Input channel: i_valid / o_stall carry kind, source and destination pixel,
// destination address and the span-last flag. Output channel: o_valid /
// i_stall carry the result pixel, write enable and span-last copy.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 global alpha, 1 pen colour); write only while the pipeline is empty.
// An accepted input transaction is registered through three register stages
// (mode prep, alpha scale and hash, channel blend) and then drives o_valid;
// while i_stall stays low, throughput is one pixel per cycle, each stage
// taking a transaction every clock.
// Reset clears all stage valids and loads global alpha 15 and pen colour 0.
// When the receiver stalls, the result holds and empty stages behind it still
// fill; o_stall rises only once all three stages hold a transaction.
// ----------------------------------------------------------------------------
module rgba4444_pixel_blend_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_kind,
    input  logic [15:0] i_source_pixel,
    input  logic [15:0] i_dest_pixel,
    input  logic [31:0] i_dest_address,
    input  logic        i_span_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_result_pixel,
    output logic        o_write_enable,
    output logic        o_result_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import rpb_pkg::*;

    logic [3:0]  r_global_alpha;
    logic [15:0] r_pen_color;
    logic        r_v1;
    logic        r_v2;
    logic        r_v3;
    logic        en1;
    logic        en2;
    logic        en3;
    t_s1         s1;
    t_s2         s2;
    t_s3         s3;

    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_alpha <= GLOBAL_ALPHA_RST;
            r_pen_color    <= PEN_COLOR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GLOBAL_ALPHA: r_global_alpha <= i_cfg_data[3:0];
                CFG_PEN_COLOR:    r_pen_color    <= i_cfg_data;
                default:          r_pen_color    <= r_pen_color;
            endcase
        end
    end

    rpb_prep u_prep (
        .i_clk          (i_clk),
        .i_en           (en1),
        .i_kind         (i_kind),
        .i_source_pixel (i_source_pixel),
        .i_dest_pixel   (i_dest_pixel),
        .i_dest_address (i_dest_address),
        .i_span_last    (i_span_last),
        .i_pen_color    (r_pen_color),
        .o_s1           (s1)
    );

    rpb_alpha u_alpha (
        .i_clk          (i_clk),
        .i_en           (en2),
        .i_s1           (s1),
        .i_global_alpha (r_global_alpha),
        .o_s2           (s2)
    );

    rpb_blend u_blend (
        .i_clk (i_clk),
        .i_en  (en3),
        .i_s2  (s2),
        .o_s3  (s3)
    );

    assign o_valid        = r_v3;
    assign o_result_pixel = s3.pix;
    assign o_write_enable = s3.we;
    assign o_result_last  = s3.last;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled while a pipeline stage is empty");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_v1 && !r_v2 && !r_v3))
        else $error("pipeline holds a transaction after reset");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted transaction lost at the first stage");

    a_advance_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && en3) |=> r_v3)
        else $error("transaction lost between blend stages");

endmodule

// ===== rtl/rpb_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpb_prep
// First stage: decode the mode, build the pixel to blend, run the first two
// rounds of the dissolve address hash.
// ----------------------------------------------------------------------------
module rpb_prep (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [3:0]     i_kind,
    input  logic [15:0]    i_source_pixel,
    input  logic [15:0]    i_dest_pixel,
    input  logic [31:0]    i_dest_address,
    input  logic           i_span_last,
    input  logic [15:0]    i_pen_color,
    output rpb_pkg::t_s1   o_s1
);
    import rpb_pkg::*;

    t_s1          r_s1;
    t_s1          n_s1;
    logic [31:0]  v0;
    logic [31:0]  v2;
    logic [15:0]  comb_px;
    logic [7:0]   pen_prod;
    logic [3:0]   pen_a;

    function automatic logic [3:0] chan_op(input logic [3:0] kind, input logic [3:0] sc,
                                           input logic [3:0] dc);
        logic [7:0] prod;
        logic [4:0] sum;
        logic [3:0] rc;
        prod = 8'(sc) * 8'(dc);
        sum  = 5'(sc) + 5'(dc);
        case (kind)
            KIND_DARKEN:   rc = (sc < dc) ? sc : dc;
            KIND_LIGHTEN:  rc = (sc > dc) ? sc : dc;
            KIND_ADD:      rc = sum[4] ? 4'hf : sum[3:0];
            KIND_SUBTRACT: rc = (dc > sc) ? (dc - sc) : 4'h0;
            default:       rc = prod[7:4];
        endcase
        return rc;
    endfunction

    always_comb begin
        v0       = {i_dest_address[31], i_dest_address[31:1]};
        v2       = hash_round(hash_round(v0, 3'd4), 3'd3);
        pen_prod = 8'(i_pen_color[7:4]) * 8'(i_source_pixel[7:4]);
        pen_a    = 4'((9'(pen_prod) + 9'd15) >> 4);
        comb_px  = {chan_op(i_kind, i_source_pixel[15:12], i_dest_pixel[15:12]),
                    chan_op(i_kind, i_source_pixel[11:8],  i_dest_pixel[11:8]),
                    i_source_pixel[7:4],
                    chan_op(i_kind, i_source_pixel[3:0],   i_dest_pixel[3:0])};
    end

    always_comb begin
        n_s1.op   = OP_KEEP;
        n_s1.pix  = i_source_pixel;
        n_s1.dst  = i_dest_pixel;
        n_s1.hash = v2[HASH_W-1:0];
        n_s1.last = i_span_last;
        unique case (i_kind)
            KIND_ALPHA: begin
                n_s1.op = OP_BLEND;
            end
            KIND_COPY: begin
                n_s1.op = OP_SRC;
            end
            KIND_MASK: begin
                n_s1.op = (|i_source_pixel[7:4]) ? OP_SRC : OP_KEEP;
            end
            KIND_PEN: begin
                n_s1.op  = OP_BLEND;
                n_s1.pix = {i_pen_color[15:8], pen_a, i_pen_color[3:0]};
            end
            KIND_DARKEN, KIND_LIGHTEN, KIND_ADD, KIND_SUBTRACT, KIND_MULTIPLY: begin
                n_s1.op  = OP_BLEND;
                n_s1.pix = comb_px;
            end
            KIND_DISSOLVE: begin
                n_s1.op = OP_DISSOLVE;
            end
            default: begin
                n_s1.op = OP_KEEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

// ===== rtl/rpb_alpha.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpb_alpha
// Second stage: scale source alpha by global alpha and stretch to 0..16;
// finish the dissolve hash and resolve the dissolve decision.
// ----------------------------------------------------------------------------
module rpb_alpha (
    input  logic           i_clk,
    input  logic           i_en,
    input  rpb_pkg::t_s1   i_s1,
    input  logic [3:0]     i_global_alpha,
    output rpb_pkg::t_s2   o_s2
);
    import rpb_pkg::*;

    t_s2          r_s2;
    t_s2          n_s2;
    logic [7:0]   ga_prod;
    logic [3:0]   ga_a;
    logic [31:0]  v4;
    logic [3:0]   h;

    always_comb begin
        ga_prod = 8'(i_s1.pix[7:4]) * 8'(i_global_alpha);
        ga_a    = 4'((9'(ga_prod) + 9'd15) >> 4);
        v4      = hash_round(hash_round(32'(i_s1.hash), 3'd2), 3'd1);
        h       = (v4[3:0] == 4'h0) ? 4'h0 : (v4[3:0] - 4'h1);

        n_s2.op    = i_s1.op;
        n_s2.alpha = 5'(ga_a) + 5'(ga_a[3]);
        n_s2.pix   = i_s1.pix;
        n_s2.dst   = i_s1.dst;
        n_s2.last  = i_s1.last;
        if (i_s1.op == OP_DISSOLVE) begin
            n_s2.op = (h < i_s1.pix[7:4]) ? OP_SRC : OP_KEEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

// ===== rtl/rpb_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpb_blend
// Third stage: per-channel alpha blend and final pixel selection; drives the
// output register.
// ----------------------------------------------------------------------------
module rpb_blend (
    input  logic           i_clk,
    input  logic           i_en,
    input  rpb_pkg::t_s2   i_s2,
    output rpb_pkg::t_s3   o_s3
);
    import rpb_pkg::*;

    t_s3          r_s3;
    t_s3          n_s3;
    logic [4:0]   inv_a;
    logic [15:0]  blend_px;
    logic [8:0]   acc [4];

    always_comb begin
        inv_a = 5'd16 - i_s2.alpha;
        for (int i = 0; i < 4; i++) begin
            acc[i] = (9'(i_s2.pix[4*i +: 4]) * 9'(i_s2.alpha))
                   + (9'(i_s2.dst[4*i +: 4]) * 9'(inv_a)) + 9'd15;
            blend_px[4*i +: 4] = acc[i][7:4];
        end

        n_s3.last = i_s2.last;
        case (i_s2.op)
            OP_BLEND: begin
                n_s3.pix = blend_px;
                n_s3.we  = 1'b1;
            end
            OP_SRC: begin
                n_s3.pix = i_s2.pix;
                n_s3.we  = 1'b1;
            end
            default: begin
                n_s3.pix = i_s2.dst;
                n_s3.we  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

// ===== tb/tb_rgba4444_pixel_blend_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgba4444_pixel_blend_unit
// Self-checking bench for the RGBA4444 pixel blend unit. A queue-fed driver
// offers pixel transactions under random idling, and a monitor predicts each
// accepted transaction with an independent blend model and checks every
// returned pixel, write enable and span flag in order. Directed pixels cover
// every mode, undefined kinds and channel extremes, then random batches run
// under several global alpha / pen colour settings and backpressure profiles.
// ----------------------------------------------------------------------------
module tb_rgba4444_pixel_blend_unit;
    import rpb_pkg::*;

    localparam int          WATCHDOG_CYCLES  = 3000;
    localparam int          LONG_HOLD_CYCLES = 80;
    localparam int          BATCH_ITEMS      = 250;
    localparam int          BATCH_COUNT      = 6;
    localparam int          REPORT_LIMIT     = 10;
    localparam logic [3:0]  KIND_UNDEF_LO    = 4'd10;
    localparam logic [3:0]  KIND_UNDEF_HI    = 4'd15;

    typedef struct {
        logic [3:0]  kind;
        logic [15:0] src;
        logic [15:0] dest;
        logic [31:0] addr;
        logic        last;
    } t_pixel_job;

    typedef struct {
        logic [15:0] pixel;
        logic        we;
        logic        last;
    } t_pixel_result;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_stall;
    logic [3:0]  i_kind         = '0;
    logic [15:0] i_source_pixel = '0;
    logic [15:0] i_dest_pixel   = '0;
    logic [31:0] i_dest_address = '0;
    logic        i_span_last    = 1'b0;
    logic        o_valid;
    logic        i_stall        = 1'b0;
    logic [15:0] o_result_pixel;
    logic        o_write_enable;
    logic        o_result_last;
    logic        i_cfg_we       = 1'b0;
    t_cfg_index  i_cfg_index    = CFG_GLOBAL_ALPHA;
    logic [15:0] i_cfg_data     = '0;

    logic [3:0]    ga_copy  = GLOBAL_ALPHA_RST;
    logic [15:0]   pen_copy = PEN_COLOR_RST;

    t_pixel_job    pixel_jobs_q[$];
    t_pixel_result pixel_expect_q[$];
    t_pixel_job    drv_job;

    logic src_taken    = 1'b0;
    int   src_idle_pct = 0;
    int   rcv_idle_pct = 0;
    int   fail_count   = 0;
    logic hold_req     = 1'b0;
    logic hold_ack     = 1'b0;
    int   hold_left    = 0;

    rgba4444_pixel_blend_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_source_pixel (i_source_pixel),
        .i_dest_pixel   (i_dest_pixel),
        .i_dest_address (i_dest_address),
        .i_span_last    (i_span_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_pixel (o_result_pixel),
        .o_write_enable (o_write_enable),
        .o_result_last  (o_result_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Blend model
    // ------------------------------------------------------------------
    function automatic logic [4:0] scale_alpha(logic [3:0] src_a);
        logic [7:0] prod;
        logic [4:0] a;
        prod = src_a * ga_copy + 8'd15;
        a = {1'b0, prod[7:4]};
        return a + a[3];
    endfunction

    function automatic logic [15:0] blend_over(logic [15:0] s, logic [15:0] d);
        logic [4:0]  a;
        logic [8:0]  acc;
        logic [15:0] r;
        a = scale_alpha(s[7:4]);
        for (int c = 0; c < 4; c++) begin
            acc = s[4*c +: 4] * a + d[4*c +: 4] * (5'd16 - a) + 9'd15;
            r[4*c +: 4] = acc[7:4];
        end
        return r;
    endfunction

    function automatic logic [15:0] lane_combine(logic [15:0] s, logic [15:0] d,
                                                 logic [3:0] kind);
        logic [15:0] r;
        logic [3:0]  sc;
        logic [3:0]  dc;
        logic [4:0]  sum;
        logic [7:0]  prod;
        r = s & 16'h00f0;
        for (int c = 0; c < 4; c++) begin
            if (c != 1) begin
                sc = s[4*c +: 4];
                dc = d[4*c +: 4];
                sum = sc + dc;
                prod = sc * dc;
                case (kind)
                    KIND_DARKEN:   r[4*c +: 4] = (sc < dc) ? sc : dc;
                    KIND_LIGHTEN:  r[4*c +: 4] = (sc > dc) ? sc : dc;
                    KIND_ADD:      r[4*c +: 4] = sum[4] ? 4'hf : sum[3:0];
                    KIND_SUBTRACT: r[4*c +: 4] = (dc > sc) ? dc - sc : 4'h0;
                    default:       r[4*c +: 4] = prod[7:4];
                endcase
            end
        end
        return r;
    endfunction

    function automatic logic dissolve_hit(logic [31:0] addr, logic [3:0] src_a);
        logic [31:0] v;
        logic [3:0]  h;
        v = {addr[31], addr[31:1]};
        for (int n = 4; n > 0; n--)
            v = ((v >> 8) ^ v) * 32'h0000_00d2 + 32'(n);
        h = v[3:0];
        if (h != 4'h0)
            h = h - 4'h1;
        return h < src_a;
    endfunction

    function automatic t_pixel_result predict_pixel(t_pixel_job j);
        t_pixel_result r;
        logic [7:0]    pen_prod;
        logic [15:0]   pen_px;
        r.pixel = j.dest;
        r.we = 1'b0;
        r.last = j.last;
        pen_prod = pen_copy[7:4] * j.src[7:4] + 8'd15;
        pen_px = (pen_copy & 16'hff0f) | {8'h00, pen_prod[7:4], 4'h0};
        case (j.kind)
            KIND_ALPHA: begin
                r.pixel = blend_over(j.src, j.dest);
                r.we = 1'b1;
            end
            KIND_COPY: begin
                r.pixel = j.src;
                r.we = 1'b1;
            end
            KIND_MASK: begin
                if (j.src[7:4] != 4'h0) begin
                    r.pixel = j.src;
                    r.we = 1'b1;
                end
            end
            KIND_PEN: begin
                r.pixel = blend_over(pen_px, j.dest);
                r.we = 1'b1;
            end
            KIND_DARKEN, KIND_LIGHTEN, KIND_ADD, KIND_SUBTRACT, KIND_MULTIPLY: begin
                r.pixel = blend_over(lane_combine(j.src, j.dest, j.kind), j.dest);
                r.we = 1'b1;
            end
            KIND_DISSOLVE: begin
                if (dissolve_hit(j.addr, j.src[7:4])) begin
                    r.pixel = j.src;
                    r.we = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_pixel_job make_job(logic [3:0] kind, logic [15:0] src,
                                            logic [15:0] dest, logic [31:0] addr,
                                            logic last);
        t_pixel_job j;
        j.kind = kind;
        j.src = src;
        j.dest = dest;
        j.addr = addr;
        j.last = last;
        return j;
    endfunction

    function automatic logic [3:0] pick_nibble();
        case ($urandom_range(3))
            0:       return 4'h0;
            1:       return 4'hf;
            default: return 4'($urandom);
        endcase
    endfunction

    function automatic t_pixel_job random_job();
        logic [3:0] kind;
        if ($urandom_range(99) < 6)
            kind = 4'($urandom_range(KIND_UNDEF_HI, KIND_UNDEF_LO));
        else
            kind = 4'($urandom_range(KIND_DISSOLVE, KIND_ALPHA));
        return make_job(kind,
                        {pick_nibble(), pick_nibble(), pick_nibble(), pick_nibble()},
                        {pick_nibble(), pick_nibble(), pick_nibble(), pick_nibble()},
                        $urandom, 1'($urandom));
    endfunction

    task automatic write_reg(t_cfg_index idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_GLOBAL_ALPHA)
            ga_copy = val[3:0];
        else
            pen_copy = val;
    endtask

    task automatic drain_pipe();
        do
            @(posedge i_clk);
        while (pixel_jobs_q.size() != 0 || i_valid || pixel_expect_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: hold the payload until accepted, then advance or idle
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_valid || src_taken) begin
            if (pixel_jobs_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                drv_job = pixel_jobs_q.pop_front();
                i_valid <= 1'b1;
                i_kind <= drv_job.kind;
                i_source_pixel <= drv_job.src;
                i_dest_pixel <= drv_job.dest;
                i_dest_address <= drv_job.addr;
                i_span_last <= drv_job.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure: random stalls, or a long hold on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= LONG_HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input transactions, check output transactions
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_pixel_job    taken;
        t_pixel_result want;
        src_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                taken = make_job(i_kind, i_source_pixel, i_dest_pixel,
                                 i_dest_address, i_span_last);
                pixel_expect_q.push_back(predict_pixel(taken));
            end
            if (o_valid && !i_stall) begin
                if (pixel_expect_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result: pixel %h we %b last %b",
                                 o_result_pixel, o_write_enable, o_result_last);
                end else begin
                    want = pixel_expect_q.pop_front();
                    if (o_result_pixel !== want.pixel || o_write_enable !== want.we ||
                        o_result_last !== want.last) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("mismatch: pixel/we/last exp %h %b %b got %h %b %b",
                                     want.pixel, want.we, want.last,
                                     o_result_pixel, o_write_enable, o_result_last);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("tb_rgba4444_pixel_blend_unit: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        logic [15:0] cfg_word;
        logic [15:0] pen_pick;
        logic [3:0]  ga_pick;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: global alpha full, pen black
        src_idle_pct = 13;
        rcv_idle_pct = 68;
        pixel_jobs_q.push_back(make_job(KIND_ALPHA,    16'h0000, 16'hffff, 32'h0, 1'b0));
        pixel_jobs_q.push_back(make_job(KIND_ALPHA,    16'hffff, 16'h0000, 32'h0, 1'b1));
        pixel_jobs_q.push_back(make_job(KIND_ALPHA,    16'h5a75, 16'h3c1e, 32'h0, 1'b0));
        pixel_jobs_q.push_back(make_job(KIND_ALPHA,    16'hf08f, 16'h0f70, 32'h0, 1'b0));
        pixel_jobs_q.push_back(make_job(KIND_COPY,     16'hffff, 16'h1234, 32'h0, 1'b1));
        pixel_jobs_q.push_back(make_job(KIND_COPY,     16'h0000, 16'hffff, 32'h0, 1'b0));
        pixel_jobs_q.push_back(make_job(KIND_MASK,     16'hff0f, 16'h1234, 32'h0, 1'b0));
        pixel_jobs_q.push_back(make_job(KIND_MASK,     16'h0010, 16'hffff, 32'h0, 1'b1));
        pixel_jobs_q.push_back(make_job(KIND_PEN,      16'h00f0, 16'h8421, 32'h0, 1'b0));
        pixel_jobs_q.push_back(make_job(KIND_DARKEN,   16'hffff, 16'h0000, 32'h0, 1'b0));
        pixel_jobs_q.push_back(make_job(KIND_LIGHTEN,  16'h0ff0, 16'hf00f, 32'h0, 1'b0));
        pixel_jobs_q.push_back(make_job(KIND_ADD,      16'hf8f8, 16'h8f8f, 32'h0, 1'b0));
        pixel_jobs_q.push_back(make_job(KIND_SUBTRACT, 16'h1f12, 16'h0f25, 32'h0, 1'b1));
        pixel_jobs_q.push_back(make_job(KIND_MULTIPLY, 16'hffff, 16'hffff, 32'h0, 1'b0));
        pixel_jobs_q.push_back(make_job(KIND_MULTIPLY, 16'h7f37, 16'h9e5b, 32'h0, 1'b0));
        pixel_jobs_q.push_back(make_job(KIND_DISSOLVE, 16'hff0f, 16'h1111, 32'h0000_0000, 1'b0));
        pixel_jobs_q.push_back(make_job(KIND_DISSOLVE, 16'h12f4, 16'h2222, 32'hffff_ffff, 1'b1));
        pixel_jobs_q.push_back(make_job(KIND_DISSOLVE, 16'h3486, 16'h3333, 32'h8000_0000, 1'b0));
        pixel_jobs_q.push_back(make_job(KIND_DISSOLVE, 16'h5617, 16'h4444, 32'h7fff_fffe, 1'b0));
        pixel_jobs_q.push_back(make_job(KIND_UNDEF_LO, 16'hffff, 16'h5a5a, 32'h0, 1'b1));
        pixel_jobs_q.push_back(make_job(KIND_UNDEF_HI, 16'h0000, 16'ha5a5, 32'h0, 1'b0));
        drain_pipe();

        // global alpha zero, pen white
        write_reg(CFG_GLOBAL_ALPHA, 16'hfff0);
        write_reg(CFG_PEN_COLOR, 16'hffff);
        pixel_jobs_q.push_back(make_job(KIND_PEN,      16'h00f0, 16'h1234, 32'h0, 1'b0));
        pixel_jobs_q.push_back(make_job(KIND_ALPHA,    16'hffff, 16'h0000, 32'h0, 1'b1));
        pixel_jobs_q.push_back(make_job(KIND_ADD,      16'hffff, 16'h7777, 32'h0, 1'b0));
        drain_pipe();

        for (int b = 0; b < BATCH_COUNT; b++) begin
            case (b)
                0:       ga_pick = 4'hf;
                3:       ga_pick = 4'h0;
                default: ga_pick = 4'($urandom);
            endcase
            case (b)
                3:       pen_pick = 16'h0000;
                5:       pen_pick = 16'hffff;
                default: pen_pick = 16'($urandom);
            endcase
            cfg_word = 16'($urandom);
            cfg_word[3:0] = ga_pick;
            write_reg(CFG_GLOBAL_ALPHA, cfg_word);
            write_reg(CFG_PEN_COLOR, pen_pick);

            if (b < 2) begin
                src_idle_pct = 13;
                rcv_idle_pct = 68;
            end else if (b < 4) begin
                src_idle_pct = 68;
                rcv_idle_pct = 13;
            end else begin
                src_idle_pct = 0;
                rcv_idle_pct = 0;
            end

            // hold the receiver off while the sender keeps offering
            if (b == 4)
                hold_req = ~hold_req;

            for (int k = 0; k < BATCH_ITEMS; k++)
                pixel_jobs_q.push_back(random_job());
            drain_pipe();
        end

        if (fail_count == 0 && pixel_expect_q.size() == 0)
            $display("tb_rgba4444_pixel_blend_unit: done, clean");
        else
            $display("tb_rgba4444_pixel_blend_unit: done, errors");
        $finish;
    end

endmodule

// ===== rgba4444_pixel_blend_unit.f =====
rtl/rpb_pkg.sv
rtl/rpb_prep.sv
rtl/rpb_alpha.sv
rtl/rpb_blend.sv
rtl/rgba4444_pixel_blend_unit.sv
tb/tb_rgba4444_pixel_blend_unit.sv
